>>> rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared widths, command codes and types of the ARP cache table.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int ENTRIES_DEF = 24;
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int SLOT_W      = 5;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // write request from the sequencer to the table memory
  typedef struct packed {
    logic             en;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } wr_req_t;

endpackage

>>> rtl/core/arp_cache_fifo_table_unit.sv
// ----------------------------------------------------------------------------
// arp_cache_fifo_table_unit
// Associative IPv4-to-MAC cache with ring (oldest-first) replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_command, in_ip_address and in_mac_address and
//   raise start; the word is taken at an edge where busy is low.
//   Insert (in_command = 1) writes the pair at the ring pointer and returns
//   the written slot in the cycle after acceptance; a new word may be taken in
//   the very next cycle.
//   Lookup (in_command = 0) walks the filled slots from slot 0, one memory
//   read per cycle; busy stays high while it walks. The table memory has a
//   single registered read port, so each slot is compared in the cycle after
//   it is read. A hit is reported for the first matching slot, a miss after
//   the last filled slot; on an empty table a miss is reported without a scan.
//   A new word is taken at the end of the result cycle.
//   Result channel: out_valid is high for exactly one cycle with out_hit,
//   out_slot_index and out_mac_found; the receiver cannot stall it.
//   Reset (rst_n low, synchronous) empties the table: pointer and fill count
//   clear at once, stored pairs are not cleared and are never compared.
// ----------------------------------------------------------------------------
module arp_cache_fifo_table_unit #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [arpc_pkg::IP_W-1:0]   in_ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]  in_mac_address,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [arpc_pkg::SLOT_W-1:0] out_slot_index,
  output logic [arpc_pkg::MAC_W-1:0]  out_mac_found
);
  import arpc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  wr_req_t          wr_req;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;

  arpc_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_ip_address  (in_ip_address),
    .in_mac_address (in_mac_address),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_slot_index (out_slot_index),
    .out_mac_found  (out_mac_found),
    .wr_req         (wr_req),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .rd_ip          (rd_ip),
    .rd_mac         (rd_mac)
  );

  arpc_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_req  (wr_req),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .rd_ip   (rd_ip),
    .rd_mac  (rd_mac)
  );

endmodule

>>> rtl/core/arpc_mem.sv
// ----------------------------------------------------------------------------
// arpc_mem
// Address/MAC pair storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arpc_mem #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                     clk,
  input  arpc_pkg::wr_req_t        wr_req,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic [arpc_pkg::IP_W-1:0]  rd_ip,
  output logic [arpc_pkg::MAC_W-1:0] rd_mac
);
  import arpc_pkg::*;

  logic [IP_W-1:0]  ip_mem  [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      ip_mem[wr_addr]  <= wr_req.ip;
      mac_mem[wr_addr] <= wr_req.mac;
    end
  end

  always_ff @(posedge clk) begin
    rd_ip  <= ip_mem[rd_addr];
    rd_mac <= mac_mem[rd_addr];
  end

endmodule

>>> rtl/core/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Command sequencer: ring write pointer, fill count and the lookup scan
// that walks the filled slots one read per cycle.
// ----------------------------------------------------------------------------
module arpc_ctrl #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES),
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [arpc_pkg::IP_W-1:0]   in_ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]  in_mac_address,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [arpc_pkg::SLOT_W-1:0] out_slot_index,
  output logic [arpc_pkg::MAC_W-1:0]  out_mac_found,
  output arpc_pkg::wr_req_t           wr_req,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [arpc_pkg::IP_W-1:0]   rd_ip,
  input  logic [arpc_pkg::MAC_W-1:0]  rd_mac
);
  import arpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [IP_W-1:0]    key_r, key_nxt;
  logic               valid_r, valid_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [MAC_W-1:0]   mac_r, mac_nxt;

  always_comb begin
    state_nxt    = state_r;
    wr_ptr_nxt   = wr_ptr_r;
    fill_nxt     = fill_r;
    scan_idx_nxt = scan_idx_r;
    key_nxt      = key_r;
    valid_nxt    = 1'b0;
    hit_nxt      = 1'b0;
    slot_nxt     = '0;
    mac_nxt      = '0;
    wr_req.en    = 1'b0;
    wr_req.ip    = in_ip_address;
    wr_req.mac   = in_mac_address;
    rd_addr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_INSERT) begin
            wr_req.en = 1'b1;
            valid_nxt = 1'b1;
            slot_nxt  = wr_ptr_r;
            // wrap the ring after the last slot
            if (wr_ptr_r == IDX_W'(ENTRIES - 1)) begin
              wr_ptr_nxt = '0;
            end else begin
              wr_ptr_nxt = wr_ptr_r + IDX_W'(1);
            end
            if (fill_r != CNT_W'(ENTRIES)) begin
              fill_nxt = fill_r + CNT_W'(1);
            end
          end else if (fill_r == '0) begin
            valid_nxt = 1'b1;
          end else begin
            // slot 0 is read on this edge, compared next cycle
            key_nxt      = in_ip_address;
            scan_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_ip == key_r) begin
          valid_nxt = 1'b1;
          hit_nxt   = 1'b1;
          slot_nxt  = scan_idx_r;
          mac_nxt   = rd_mac;
          state_nxt = ST_IDLE;
        end else if ((CNT_W'(scan_idx_r) + CNT_W'(1)) == fill_r) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          rd_addr      = scan_idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    mac_r      <= mac_nxt;
  end

  assign wr_addr        = wr_ptr_r;
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = valid_r;
  assign out_hit        = hit_r;
  assign out_slot_index = SLOT_W'(slot_r);
  assign out_mac_found  = mac_r;

endmodule

>>> rtl/core/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks of the ARP cache table, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_command,
  input logic                        out_valid,
  input logic                        out_hit,
  input logic [arpc_pkg::MAC_W-1:0]  out_mac_found
);
  import arpc_pkg::*;

  // an insert answers in the next cycle, never as a hit
  a_insert_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_INSERT) |=> (out_valid && !out_hit))
    else $error("insert word did not answer in the next cycle");

  // every accepted word either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word neither answered nor started a scan");

  // a scan ends only with a result
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without a result word");

  // no result word without a word in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result word with no accepted word");

  // a non-hit result carries no MAC
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_mac_found == '0))
    else $error("non-hit result with nonzero MAC");

endmodule

bind arp_cache_fifo_table_unit arpc_checker u_arpc_checker (.*);
